// ----- rtl/idle_dimming_brightness_controller_defines.svh -----
// assertion macros for the idle dimming brightness controller checks
`ifndef IDLE_DIMMING_BRIGHTNESS_CONTROLLER_DEFINES_SVH
`define IDLE_DIMMING_BRIGHTNESS_CONTROLLER_DEFINES_SVH

// check that sleeps while reset is high
`define IDBC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("idbc check failed");

// check that also runs across reset
`define IDBC_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("idbc reset check failed");

`endif

// ----- rtl/idbc_pkg.sv -----
// shared widths, constants, types and helpers of the brightness controller
package idbc_pkg;

   localparam int FRAC_BITS  = 10;
   localparam int TIME_BITS  = 32;
   localparam int LEVEL_W    = 11;
   localparam int TICK_W     = 16;
   localparam int LEFT_W     = 32;
   localparam int DUR_W      = 16;
   localparam int WIN_W      = 22;
   localparam int QUOT_W     = FRAC_BITS + 1;
   localparam int PROD_W     = QUOT_W + DUR_W;
   localparam int QCNT_W     = $clog2(QUOT_W);
   localparam int HF_W       = DUR_W + 1;
   localparam int THR_W      = DUR_W + 2;
   localparam int WIDE_W     = ((TIME_BITS > WIN_W) ? TIME_BITS : WIN_W) + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WIN_W;

   localparam logic [LEVEL_W-1:0]   FULL_LEVEL = LEVEL_W'(2 ** FRAC_BITS);
   localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};

   // register reset values
   localparam logic [LEVEL_W-1:0] RST_DIM_LEVEL     = LEVEL_W'(307);
   localparam logic [DUR_W-1:0]   RST_RUN_FADE      = DUR_W'(10 * 1000);
   localparam logic [WIN_W-1:0]   RST_FOCUS_WINDOW  = WIN_W'(30 * 1000);
   localparam logic [DUR_W-1:0]   RST_FOCUS_RAMP    = DUR_W'(3 * 1000);
   localparam logic [DUR_W-1:0]   RST_IDLE_HOLD     = DUR_W'(10 * 1000);
   localparam logic [DUR_W-1:0]   RST_IDLE_FADE     = DUR_W'(3 * 1000);
   localparam logic [DUR_W-1:0]   RST_IDLE_DIM_HOLD = DUR_W'(5 * 1000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_LEVEL     = 3'd0,
      CSR_RUN_FADE      = 3'd1,
      CSR_FOCUS_WINDOW  = 3'd2,
      CSR_FOCUS_RAMP    = 3'd3,
      CSR_IDLE_HOLD     = 3'd4,
      CSR_IDLE_FADE     = 3'd5,
      CSR_IDLE_DIM_HOLD = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      LVL_FULL = 3'd0,
      LVL_ZERO = 3'd1,
      LVL_DIM  = 3'd2,
      LVL_FADE = 3'd3,
      LVL_RAMP = 3'd4
   } lvl_kind_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] dim_floor;
      logic [QUOT_W-1:0]  span;
      logic [DUR_W-1:0]   run_fade;
      logic [WIN_W-1:0]   focus_window;
      logic [DUR_W-1:0]   focus_ramp;
      logic [DUR_W-1:0]   idle_hold;
      logic [DUR_W-1:0]   idle_fade;
      logic [HF_W-1:0]    hold_fade;
      logic [THR_W-1:0]   sleep_thr;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [QUOT_W-1:0] span;
      logic [DUR_W-1:0]  e;
      logic [DUR_W-1:0]  d;
   } md_req_type;

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [LEFT_W-1:0] v);
      if ((LEFT_W + 1)'(v) > (LEFT_W + 1)'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return TIME_BITS'(v);
   endfunction

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TICK_W-1:0]    b);
      logic [TIME_BITS:0] s;
      s = (TIME_BITS + 1)'(a) + (TIME_BITS + 1)'(b);
      return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
   endfunction

endpackage

// ----- rtl/idbc_chan_if.sv -----
// channel interfaces: tick request, brightness response, register writes
interface idbc_req_if import idbc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TICK_W-1:0] tick_ms;
   logic              moving;
   logic              running;
   logic              has_goal;
   logic              in_break;
   logic [LEFT_W-1:0] time_left_ms;
   logic              face_switched;
   logic              woke_up;

   modport source (output valid, tick_ms, moving, running, has_goal, in_break,
                   time_left_ms, face_switched, woke_up, input ready);
   modport sink   (input valid, tick_ms, moving, running, has_goal, in_break,
                   time_left_ms, face_switched, woke_up, output ready);
endinterface

interface idbc_rsp_if import idbc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   logic               sleep_ready;

   modport source (output valid, level, sleep_ready, input ready);
   modport sink   (input valid, level, sleep_ready, output ready);
endinterface

interface idbc_csr_if import idbc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/idbc_csr.sv -----
// configuration registers and the values derived from them
module idbc_csr import idbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   idbc_csr_if.sink   csr,
   output cfg_type    cfg
);

   logic [LEVEL_W-1:0] dim_ff;
   logic [DUR_W-1:0]   run_fade_ff;
   logic [WIN_W-1:0]   focus_window_ff;
   logic [DUR_W-1:0]   focus_ramp_ff;
   logic [DUR_W-1:0]   idle_hold_ff;
   logic [DUR_W-1:0]   idle_fade_ff;
   logic [DUR_W-1:0]   idle_dim_hold_ff;
   logic [LEVEL_W-1:0] dim_floor;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff           <= RST_DIM_LEVEL;
         run_fade_ff      <= RST_RUN_FADE;
         focus_window_ff  <= RST_FOCUS_WINDOW;
         focus_ramp_ff    <= RST_FOCUS_RAMP;
         idle_hold_ff     <= RST_IDLE_HOLD;
         idle_fade_ff     <= RST_IDLE_FADE;
         idle_dim_hold_ff <= RST_IDLE_DIM_HOLD;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_DIM_LEVEL:     dim_ff           <= csr.data[LEVEL_W-1:0];
            CSR_RUN_FADE:      run_fade_ff      <= csr.data[DUR_W-1:0];
            CSR_FOCUS_WINDOW:  focus_window_ff  <= csr.data[WIN_W-1:0];
            CSR_FOCUS_RAMP:    focus_ramp_ff    <= csr.data[DUR_W-1:0];
            CSR_IDLE_HOLD:     idle_hold_ff     <= csr.data[DUR_W-1:0];
            CSR_IDLE_FADE:     idle_fade_ff     <= csr.data[DUR_W-1:0];
            CSR_IDLE_DIM_HOLD: idle_dim_hold_ff <= csr.data[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   // dim floor never above full
   assign dim_floor = (dim_ff > FULL_LEVEL) ? FULL_LEVEL : dim_ff;

   always_comb begin
      cfg.dim_floor    = dim_floor;
      cfg.span         = QUOT_W'(FULL_LEVEL - dim_floor);
      cfg.run_fade     = run_fade_ff;
      cfg.focus_window = focus_window_ff;
      cfg.focus_ramp   = focus_ramp_ff;
      cfg.idle_hold    = idle_hold_ff;
      cfg.idle_fade    = idle_fade_ff;
      cfg.hold_fade    = HF_W'(idle_hold_ff) + HF_W'(idle_fade_ff);
      cfg.sleep_thr    = THR_W'(idle_hold_ff) + THR_W'(idle_fade_ff)
                         + THR_W'(idle_dim_hold_ff);
   end

endmodule

// ----- rtl/idbc_muldiv.sv -----
// bit-serial span*e/d: shift-add multiply then restoring divide in one register
module idbc_muldiv import idbc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  md_req_type        req,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   typedef enum logic [2:0] {
      MD_IDLE = 3'b001,
      MD_MUL  = 3'b010,
      MD_DIV  = 3'b100
   } md_state_type;

   localparam logic [QCNT_W-1:0] CNT_LAST = QCNT_W'(QUOT_W - 1);

   md_state_type        state_ff, state_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [QUOT_W-1:0]   mplier_ff, mplier_in;
   logic [DUR_W-1:0]    mcand_ff, mcand_in;
   logic [DUR_W-1:0]    dvsr_ff, dvsr_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic                done_ff, done_in;
   logic [DUR_W:0]      rem_ext;
   logic [DUR_W:0]      rem_diff;
   logic                rem_ge;
   logic [PROD_W-1:0]   addend;

   // upper part of acc is the partial remainder, lower part shifts dividend out
   assign rem_ext  = {acc_ff[PROD_W-1:QUOT_W], acc_ff[QUOT_W-1]};
   assign rem_ge   = rem_ext >= {1'b0, dvsr_ff};
   assign rem_diff = rem_ext - {1'b0, dvsr_ff};
   assign addend   = mplier_ff[QUOT_W-1] ? PROD_W'(mcand_ff) : '0;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      dvsr_in   = dvsr_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               mplier_in = req.span;
               mcand_in  = req.e;
               dvsr_in   = req.d;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            acc_in    = {acc_ff[PROD_W-2:0], 1'b0} + addend;
            mplier_in = {mplier_ff[QUOT_W-2:0], 1'b0};
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         MD_DIV: begin
            acc_in = {(rem_ge ? rem_diff[DUR_W-1:0] : rem_ext[DUR_W-1:0]),
                      acc_ff[QUOT_W-2:0], rem_ge};
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      dvsr_ff   <= dvsr_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign quot = acc_ff[QUOT_W-1:0];

endmodule

// ----- rtl/idle_dimming_brightness_controller.sv -----
// top level of the idle dimming brightness controller
//
//  channel  | dir | handshake     | word
//  req_ch   | in  | valid/ready   | tick_ms, moving, running, has_goal, in_break,
//           |     |               | time_left_ms, face_switched, woke_up
//  rsp_ch   | out | valid/ready   | level, sleep_ready
//  csr_ch   | in  | valid/ready   | index, data (register write, always ready)
//
// one tick word is worked at a time: req_ch.ready is high only when idle
// a tick with a fade or ramp passes the count and select stages, then waits in the
// bit-serial multiply-divide (11 multiply and 11 divide steps) before finish;
// other ticks go from select straight to finish
// the result sits in an output register, so the next tick is taken while it waits
// reset clears the counters, status history, registers and the output valid
module idle_dimming_brightness_controller import idbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   idbc_req_if.sink    req_ch,
   idbc_rsp_if.source  rsp_ch,
   idbc_csr_if.sink    csr_ch
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_COUNT  = 5'b00010,
      ST_SELECT = 5'b00100,
      ST_CALC   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   cfg_type cfg;

   state_type              state_ff, state_in;

   // captured tick word
   logic [TICK_W-1:0]      tick_ff;
   logic                   moving_ff, running_ff, goal_ff, break_ff;
   logic                   switched_ff, woke_ff;
   logic [TIME_BITS-1:0]   left_ff;

   // history kept between ticks
   logic [TIME_BITS-1:0]   bright_ff, bright_in;
   logic [TIME_BITS-1:0]   paused_ff, paused_in;
   logic                   last_run_ff, last_run_in;
   logic                   last_goal_ff, last_goal_in;
   logic [TIME_BITS-1:0]   last_left_ff, last_left_in;
   logic                   interact_ff, interact_in;

   // per-tick decision
   lvl_kind_type           kind_ff, kind_in;
   logic                   sleep_ff, sleep_in;
   md_req_type             md_req_ff, md_req_in;
   logic                   md_done;
   logic [QUOT_W-1:0]      md_quot;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]     rsp_level_ff, rsp_level_in;
   logic                   rsp_sleep_ff, rsp_sleep_in;

   logic                   req_take;
   logic                   rsp_load;
   logic [LEVEL_W-1:0]     level_out;

   // history after a face switch / wake-up, as seen by this tick
   logic                   eff_last_run, eff_last_goal;
   logic [TIME_BITS-1:0]   eff_last_left, eff_bright, eff_paused;
   logic                   started, stopped, jumped, interacting;

   // select-stage compares
   logic [WIDE_W-1:0]      win_gap;
   logic [WIDE_W-1:0]      idle_off;
   logic                   in_window, ramp_done, fade_done;
   logic                   idle_dark, idle_past_hold, idle_past_fade;

   idbc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   idbc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req_ff),
      .done  (md_done),
      .quot  (md_quot)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   // ---- count stage: apply clears, detect interaction, advance counters ----
   always_comb begin
      eff_last_run  = switched_ff ? 1'b0 : last_run_ff;
      eff_last_goal = switched_ff ? 1'b0 : last_goal_ff;
      eff_last_left = switched_ff ? '0 : last_left_ff;
      eff_bright    = switched_ff ? '0 : bright_ff;
      eff_paused    = (switched_ff || woke_ff) ? '0 : paused_ff;

      started     = running_ff && !eff_last_run;
      stopped     = !running_ff && eff_last_run;
      // sum taken one bit wider so the phase jump test never wraps
      jumped      = goal_ff && eff_last_goal &&
                    ((TIME_BITS + 1)'(left_ff) >
                     ((TIME_BITS + 1)'(eff_last_left) + (TIME_BITS + 1)'(tick_ff)));
      interacting = started || stopped || jumped || moving_ff;

      if (interacting) begin
         eff_bright = '0;
         eff_paused = '0;
      end
   end

   always_comb begin
      bright_in    = bright_ff;
      paused_in    = paused_ff;
      last_run_in  = last_run_ff;
      last_goal_in = last_goal_ff;
      last_left_in = last_left_ff;
      interact_in  = interact_ff;
      if (state_ff == ST_COUNT) begin
         if (running_ff) begin
            paused_in = '0;
            bright_in = sat_add(eff_bright, tick_ff);
         end else begin
            paused_in = sat_add(eff_paused, tick_ff);
            bright_in = eff_bright;
         end
         last_run_in  = running_ff;
         last_goal_in = goal_ff;
         last_left_in = left_ff;
         interact_in  = interacting;
      end
   end

   // ---- select stage: pick the curve and its operands ----
   assign win_gap        = WIDE_W'(cfg.focus_window) - WIDE_W'(left_ff);
   assign in_window      = WIDE_W'(left_ff) <= WIDE_W'(cfg.focus_window);
   assign ramp_done      = win_gap >= WIDE_W'(cfg.focus_ramp);
   assign fade_done      = WIDE_W'(bright_ff) >= WIDE_W'(cfg.run_fade);
   assign idle_off       = WIDE_W'(paused_ff) - WIDE_W'(cfg.idle_hold);
   assign idle_dark      = WIDE_W'(paused_ff) >= WIDE_W'(cfg.sleep_thr);
   assign idle_past_hold = WIDE_W'(paused_ff) >= WIDE_W'(cfg.idle_hold);
   assign idle_past_fade = WIDE_W'(paused_ff) >= WIDE_W'(cfg.hold_fade);

   always_comb begin
      kind_in   = kind_ff;
      sleep_in  = sleep_ff;
      md_req_in = '0;
      md_req_in.span = cfg.span;
      if (state_ff == ST_SELECT) begin
         sleep_in = idle_dark;
         if (running_ff) begin
            if (break_ff) begin
               kind_in = LVL_FULL;
            end else if (goal_ff && in_window) begin
               // focus end ramp, zero length counts as finished
               if (ramp_done) begin
                  kind_in = LVL_FULL;
               end else begin
                  kind_in         = LVL_RAMP;
                  md_req_in.start = 1'b1;
                  md_req_in.e     = DUR_W'(win_gap);
                  md_req_in.d     = cfg.focus_ramp;
               end
            end else if (!interact_ff) begin
               if (fade_done) begin
                  kind_in = LVL_DIM;
               end else begin
                  kind_in         = LVL_FADE;
                  md_req_in.start = 1'b1;
                  md_req_in.e     = DUR_W'(bright_ff);
                  md_req_in.d     = cfg.run_fade;
               end
            end else begin
               kind_in = LVL_FULL;
            end
         end else begin
            // paused: hold full, fade, hold dim, then dark
            if (idle_dark) begin
               kind_in = LVL_ZERO;
            end else if (idle_past_fade) begin
               kind_in = LVL_DIM;
            end else if (idle_past_hold) begin
               kind_in         = LVL_FADE;
               md_req_in.start = 1'b1;
               md_req_in.e     = DUR_W'(idle_off);
               md_req_in.d     = cfg.idle_fade;
            end else begin
               kind_in = LVL_FULL;
            end
         end
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            state_in = md_req_in.start ? ST_CALC : ST_FINISH;
         end
         ST_CALC: begin
            if (md_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---- result word ----
   always_comb begin
      case (kind_ff)
         LVL_FULL: level_out = FULL_LEVEL;
         LVL_ZERO: level_out = '0;
         LVL_DIM:  level_out = cfg.dim_floor;
         LVL_FADE: level_out = FULL_LEVEL - LEVEL_W'(md_quot);
         LVL_RAMP: level_out = cfg.dim_floor + LEVEL_W'(md_quot);
         default:  level_out = FULL_LEVEL;
      endcase
   end

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_sleep_in = rsp_sleep_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = level_out;
         rsp_sleep_in = sleep_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.level       = rsp_level_ff;
   assign rsp_ch.sleep_ready = rsp_sleep_ff;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bright_ff    <= '0;
         paused_ff    <= '0;
         last_run_ff  <= 1'b0;
         last_goal_ff <= 1'b0;
         last_left_ff <= '0;
         interact_ff  <= 1'b0;
         md_req_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bright_ff    <= bright_in;
         paused_ff    <= paused_in;
         last_run_ff  <= last_run_in;
         last_goal_ff <= last_goal_in;
         last_left_ff <= last_left_in;
         interact_ff  <= interact_in;
         md_req_ff    <= md_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff     <= req_ch.tick_ms;
         moving_ff   <= req_ch.moving;
         running_ff  <= req_ch.running;
         goal_ff     <= req_ch.has_goal;
         break_ff    <= req_ch.in_break;
         left_ff     <= sat_time(req_ch.time_left_ms);
         switched_ff <= req_ch.face_switched;
         woke_ff     <= req_ch.woke_up;
      end
      kind_ff      <= kind_in;
      sleep_ff     <= sleep_in;
      rsp_level_ff <= rsp_level_in;
      rsp_sleep_ff <= rsp_sleep_in;
   end

endmodule

// ----- rtl/idbc_checker.sv -----
// port-level checks of the brightness controller, bound to the top level
`include "idle_dimming_brightness_controller_defines.svh"

module idbc_checker import idbc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LEVEL_W-1:0] rsp_level,
   input logic               rsp_sleep_ready,
   input logic               csr_valid,
   input logic               csr_ready
);

   // a waiting word holds until taken
   `IDBC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) && $stable(rsp_sleep_ready))

   // brightness never above full
   `IDBC_ASSERT(a_level_range, rsp_valid |-> rsp_level <= FULL_LEVEL)

   // one tick at a time: busy right after a word is taken
   `IDBC_ASSERT(a_busy_after_take, req_valid && req_ready |=> !req_ready)

   // register writes are never stalled
   `IDBC_ASSERT(a_csr_open, csr_valid |-> csr_ready)

   // reset empties the output register
   `IDBC_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind idle_dimming_brightness_controller idbc_checker u_idbc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_level       (rsp_ch.level),
   .rsp_sleep_ready (rsp_ch.sleep_ready),
   .csr_valid       (csr_ch.valid),
   .csr_ready       (csr_ch.ready)
);
